/* design/wildcard_mask_line_search_macros.svh */
// Assertion macros used by the wildcard mask line search top level.
`ifndef WILDCARD_MASK_LINE_SEARCH_MACROS_SVH
`define WILDCARD_MASK_LINE_SEARCH_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define WMS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define WMS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wms_pkg.sv */
// Types, constants and sizes shared by the wildcard mask line search modules.
package wms_pkg;

	localparam int MASK_MAX = 64;
	localparam int CNT_W    = 32;
	localparam int OUT_W    = 32;
	localparam int IDX_W    = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;
	localparam int LEN_W    = $clog2(MASK_MAX + 1);
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [IDX_W-1:0] RCNT_LAST = IDX_W'(MASK_MAX - 1);

	localparam logic [7:0] WILD_BYTE = 8'h3F;
	localparam logic [7:0] CR_BYTE   = 8'h0D;
	localparam logic [7:0] LF_BYTE   = 8'h0A;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TEXT = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	localparam logic RES_MATCH = 1'b0;
	localparam logic RES_TOTAL = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_TEXT,
		KIND_NEWLINE,
		KIND_END
	} kind_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic [5:0] mask_index;
	} item_t;

	typedef struct packed {
		logic             result_kind;
		logic [OUT_W-1:0] text_line;
		logic [OUT_W-1:0] start_column;
		logic [OUT_W-1:0] match_total;
	} result_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] widx;
	} cmd_t;

	typedef struct packed {
		logic replay;
	} bk_status_t;

endpackage

/* design/wildcard_mask_line_search.sv */
// Wildcard mask line search, top level.
// An accepted beat is queued, popped by the back end, and its result registered.
// Throughput: one beat per cycle unless the receiver stalls; the first text
// byte after mask loads waits while the prefix match vector is rebuilt from the byte window.
// Reset: asynchronous, active low; clears queue, counters, line to 1, length to 1.
`include "wildcard_mask_line_search_macros.svh"
module wildcard_mask_line_search import wms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data
);

	logic              q_push;
	cmd_t              q_in;
	logic              q_full;
	logic              q_pop;
	logic              q_head_valid;
	cmd_t              q_head;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W-1:0] q_count_nx;
	bk_status_t        bk_status;

	wms_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (q_push),
		.cmd        (q_in)
	);

	wms_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head),
		.count      (q_count)
	);

	wms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.status       (bk_status)
	);

	assign q_count_nx = q_count + QCNT_W'(q_push) - QCNT_W'(q_pop);

	`WMS_ASSERT_NXT(a_qcount, 1'b1, q_count == $past(q_count_nx), "queue count out of step")
	`WMS_ASSERT_IMP(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")
	`WMS_ASSERT_IMP(a_no_pop_replay, bk_status.replay, !q_pop, "pop during window replay")
	`WMS_ASSERT_IMP(a_result_src, $rose(result_valid), $past(q_pop), "result without a popped command")

endmodule

/* design/wms_front.sv */
// Front end: accepts input beats, drops dead ones, classifies the rest into commands.
module wms_front import wms_pkg::*; (
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  q_full,
	output logic  push,
	output cmd_t  cmd
);

	logic keep;

	always_comb begin
		keep     = 1'b0;
		cmd.kind = KIND_TEXT;
		case (item.opcode)
			OP_LOAD: begin
				keep     = int'(item.mask_index) < MASK_MAX;
				cmd.kind = KIND_LOAD;
			end
			OP_TEXT: begin
				keep     = 1'b1;
				cmd.kind = (item.data_byte == LF_BYTE) ? KIND_NEWLINE : KIND_TEXT;
			end
			OP_END: begin
				keep     = 1'b1;
				cmd.kind = KIND_END;
			end
			default: keep = 1'b0;
		endcase
		cmd.data = item.data_byte;
		cmd.widx = IDX_W'(item.mask_index);
	end

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready && keep;

endmodule

/* design/wms_fifo.sv */
// Short command queue between front end and back end.
module wms_fifo import wms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output cmd_t              head,
	output logic [QCNT_W-1:0] count
);

	cmd_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	assign full       = cnt_q == QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign count      = cnt_q;

endmodule

/* design/wms_back.sv */
// Back end: mask lanes, byte window, prefix match vector, counters and result register.
module wms_back import wms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	output bk_status_t status
);

	typedef enum logic [1:0] {
		ST_RUN    = 2'b01,
		ST_REPLAY = 2'b10
	} state_t;

	function automatic logic byte_hit(input logic [7:0] m, input logic [7:0] t);
		byte_hit = (m == WILD_BYTE) ? (t != CR_BYTE) : (m == t);
	endfunction

	logic [7:0]          mask_q [MASK_MAX];
	logic [7:0]          win_q [MASK_MAX];
	logic [MASK_MAX-1:0] prefix_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    fill_q;
	logic [CNT_W-1:0]    line_q;
	logic [CNT_W-1:0]    col_q;
	logic [CNT_W-1:0]    tally_q;
	logic                dirty_q;
	state_t              state_q;
	logic [IDX_W-1:0]    rcnt_q;
	logic                res_valid_q;
	result_t             res_q;

	logic                out_free;
	logic                head_text;
	logic                start_replay;
	logic                replay_step;
	logic                shift_en;
	logic [7:0]          step_byte;
	logic [MASK_MAX-1:0] hit_vec;
	logic [MASK_MAX-1:0] prefix_nx;
	logic [IDX_W-1:0]    len_idx;
	logic [LEN_W-1:0]    fill_nx;
	logic [CNT_W-1:0]    col_nx;
	logic [CNT_W-1:0]    line_inc;
	logic [CNT_W-1:0]    tally_inc;
	logic [CNT_W-1:0]    len_ext;
	logic [CNT_W-1:0]    start_col;
	logic                found;
	logic                produce;
	logic [LEN_W-1:0]    cfg_len;
	result_t             res_nx;

	assign out_free     = !res_valid_q || result_ready;
	assign head_text    = head.kind == KIND_TEXT;
	assign start_replay = (state_q == ST_RUN) && head_valid && head_text && dirty_q;
	assign pop          = (state_q == ST_RUN) && head_valid && !(head_text && dirty_q) && out_free;
	assign replay_step  = state_q == ST_REPLAY;
	assign shift_en     = replay_step || (pop && head_text);
	// replay rotates the window once around, oldest byte first
	assign step_byte    = replay_step ? win_q[MASK_MAX-1] : head.data;

	for (genvar j = 0; j < MASK_MAX; j++) begin : g_lane
		assign hit_vec[j] = byte_hit(mask_q[j], step_byte);
	end

	// prefix_nx[j]: mask[0..j] matches the newest j+1 window bytes
	assign prefix_nx[0] = hit_vec[0];
	for (genvar j = 1; j < MASK_MAX; j++) begin : g_prefix
		assign prefix_nx[j] = prefix_q[j-1] & hit_vec[j];
	end

	assign len_idx   = IDX_W'(len_q - LEN_W'(1));
	assign fill_nx   = (fill_q == LEN_W'(MASK_MAX)) ? fill_q : fill_q + LEN_W'(1);
	assign col_nx    = (col_q == CNT_MAX) ? col_q : col_q + CNT_W'(1);
	assign line_inc  = (line_q == CNT_MAX) ? line_q : line_q + CNT_W'(1);
	assign tally_inc = (tally_q == CNT_MAX) ? tally_q : tally_q + CNT_W'(1);
	assign len_ext   = CNT_W'(len_q);
	assign start_col = (col_nx >= len_ext) ? col_nx - len_ext + CNT_W'(1) : CNT_W'(1);
	assign found     = pop && head_text && (fill_nx >= len_q) && prefix_nx[len_idx];
	assign produce   = found || (pop && head.kind == KIND_END);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LEN_W'(1);
		end else if (int'(cfg_data) > MASK_MAX) begin
			cfg_len = LEN_W'(MASK_MAX);
		end else begin
			cfg_len = LEN_W'(cfg_data);
		end
	end

	always_comb begin
		res_nx = '0;
		if (found) begin
			res_nx.result_kind  = RES_MATCH;
			res_nx.text_line    = OUT_W'(line_q);
			res_nx.start_column = OUT_W'(start_col);
		end else begin
			res_nx.result_kind = RES_TOTAL;
			res_nx.match_total = OUT_W'(tally_q);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_LOAD) begin
			mask_q[head.widx] <= head.data;
		end
		if (shift_en) begin
			win_q[0] <= step_byte;
			for (int k = 1; k < MASK_MAX; k++) begin
				win_q[k] <= win_q[k-1];
			end
			prefix_q <= prefix_nx;
		end
		if (out_free && produce) begin
			res_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(1);
			fill_q      <= '0;
			line_q      <= CNT_W'(1);
			col_q       <= '0;
			tally_q     <= '0;
			dirty_q     <= 1'b0;
			state_q     <= ST_RUN;
			rcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_len;
			end
			case (state_q)
				ST_RUN: begin
					if (start_replay) begin
						state_q <= ST_REPLAY;
						rcnt_q  <= '0;
					end
				end
				ST_REPLAY: begin
					rcnt_q <= rcnt_q + IDX_W'(1);
					if (rcnt_q == RCNT_LAST) begin
						state_q <= ST_RUN;
						dirty_q <= 1'b0;
					end
				end
				default: state_q <= ST_RUN;
			endcase
			if (pop) begin
				case (head.kind)
					KIND_LOAD: dirty_q <= 1'b1;
					KIND_TEXT: begin
						col_q <= col_nx;
						if (found) begin
							tally_q <= tally_inc;
							fill_q  <= '0;
						end else begin
							fill_q <= fill_nx;
						end
					end
					KIND_NEWLINE: begin
						line_q <= line_inc;
						col_q  <= '0;
						fill_q <= '0;
					end
					KIND_END: begin
						tally_q <= '0;
						fill_q  <= '0;
						col_q   <= '0;
						line_q  <= CNT_W'(1);
					end
					default: ;
				endcase
			end
			if (out_free) begin
				res_valid_q <= produce;
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign result        = res_q;
	assign status.replay = replay_step;

endmodule

/* dv/wildcard_mask_line_search_tb.sv */
// Testbench for wildcard_mask_line_search: directed and random streams checked against a predictor.
`timescale 1ns / 1ps
module wildcard_mask_line_search_tb;
	import wms_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_C    = 8'h63;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam int SETTLE_CYCLES   = 200;
	localparam int HOLDOFF_CYCLES  = 300;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int PHASES          = 12;

	class line_search_scoreboard;
		logic [7:0]  mask_bytes [MASK_MAX];
		logic [7:0]  window [MASK_MAX];
		int unsigned fill;
		int unsigned mask_len;
		logic [31:0] line_no;
		logic [31:0] column;
		logic [31:0] tally;
		result_t     hits_due [$];
		int          errors;

		function new();
			foreach (mask_bytes[i]) begin
				mask_bytes[i] = '0;
				window[i] = '0;
			end
			fill = 0;
			mask_len = 1;
			line_no = 32'd1;
			column = '0;
			tally = '0;
			errors = 0;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void set_len(logic [6:0] v);
			mask_len = (v == 0) ? 1 : ((v > MASK_MAX) ? MASK_MAX : v);
		endfunction

		function bit window_hit();
			logic [7:0] m;
			logic [7:0] t;
			for (int i = 0; i < mask_len; i++) begin
				m = mask_bytes[i];
				t = window[mask_len - 1 - i];
				if (m == WILD_BYTE) begin
					if (t == CR_BYTE)
						return 1'b0;
				end else if (m != t) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function int pending();
			return hits_due.size();
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic [31:0] len32;
			len32 = mask_len;
			r = '0;
			case (it.opcode)
				OP_LOAD: mask_bytes[it.mask_index] = it.data_byte;
				OP_END: begin
					r.result_kind = RES_TOTAL;
					r.match_total = tally;
					hits_due = {hits_due, r};
					tally = '0;
					fill = 0;
					column = '0;
					line_no = 32'd1;
				end
				OP_TEXT: begin
					if (it.data_byte == LF_BYTE) begin
						line_no = bump(line_no);
						column = '0;
						fill = 0;
					end else begin
						column = bump(column);
						for (int i = MASK_MAX - 1; i > 0; i--)
							window[i] = window[i - 1];
						window[0] = it.data_byte;
						if (fill < MASK_MAX)
							fill++;
						if (fill >= mask_len && window_hit()) begin
							tally = bump(tally);
							fill = 0;
							r.result_kind = RES_MATCH;
							r.text_line = line_no;
							r.start_column = (column >= len32) ? column - len32 + 32'd1 : 32'd1;
							hits_due = {hits_due, r};
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 40)
				$display("%0t mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (hits_due.size() == 0) begin
				report($sformatf("unexpected beat kind %0d line %0d col %0d total %0d",
					got.result_kind, got.text_line, got.start_column, got.match_total));
				return;
			end
			want = hits_due.pop_front();
			if (got.result_kind !== want.result_kind)
				report($sformatf("result_kind got %0d want %0d", got.result_kind,
					want.result_kind));
			if (got.text_line !== want.text_line)
				report($sformatf("text_line got %0d want %0d", got.text_line,
					want.text_line));
			if (got.start_column !== want.start_column)
				report($sformatf("start_column got %0d want %0d", got.start_column,
					want.start_column));
			if (got.match_total !== want.match_total)
				report($sformatf("match_total got %0d want %0d", got.match_total,
					want.match_total));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_we;
	logic [6:0] cfg_data;

	line_search_scoreboard sb = new();
	int tx_idle;
	int rx_stall;
	bit holdoff_req;
	int cycles;

	wildcard_mask_line_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("wildcard_mask_line_search_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_item(item);
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			result_ready <= ($urandom_range(99) >= rx_stall);
		end
	end

	function automatic void set_idle(int mode);
		case (mode)
			0: begin tx_idle = 0;  rx_stall = 0;  end
			1: begin tx_idle = 76; rx_stall = 0;  end
			2: begin tx_idle = 0;  rx_stall = 76; end
			default: begin tx_idle = 13; rx_stall = 13; end
		endcase
	endfunction

	function automatic logic [7:0] text_byte();
		case ($urandom_range(19))
			0: return LF_BYTE;
			1: return CR_BYTE;
			2: return 8'($urandom_range(255));
			3: return CH_DOT;
			4, 5: return WILD_BYTE;
			default: return CH_A + 8'($urandom_range(2));
		endcase
	endfunction

	function automatic logic [7:0] mask_byte();
		case ($urandom_range(19))
			0: return LF_BYTE;
			1: return 8'($urandom_range(255));
			2: return CR_BYTE;
			3, 4, 5, 6, 7, 8, 9, 10: return WILD_BYTE;
			default: return CH_A + 8'($urandom_range(2));
		endcase
	endfunction

	task automatic put(logic [1:0] op, logic [7:0] b, logic [5:0] idx);
		item_t it;
		it.opcode = op;
		it.data_byte = b;
		it.mask_index = idx;
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic quiesce();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_len(v);
	endtask

	// text that lines up with the current mask, sometimes with one byte spoiled
	task automatic send_fragment();
		logic [7:0] frag [MASK_MAX];
		int n;
		n = sb.mask_len;
		for (int i = 0; i < n; i++) begin
			if (sb.mask_bytes[i] != WILD_BYTE)
				frag[i] = sb.mask_bytes[i];
			else if ($urandom_range(3) == 0)
				frag[i] = 8'($urandom_range(255));
			else
				frag[i] = CH_A + 8'($urandom_range(2));
		end
		if ($urandom_range(9) == 0)
			frag[$urandom_range(n - 1)] = text_byte();
		for (int i = 0; i < n; i++)
			put(OP_TEXT, frag[i], 6'($urandom_range(63)));
	endtask

	initial begin
		logic [7:0] demo_text [17];
		int lens [PHASES];
		int budget;
		int r;
		int nloads;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		holdoff_req = 1'b0;
		demo_text = '{CH_A, CH_B, CH_C, CH_A, CR_BYTE, CH_C, CH_A, LF_BYTE, CH_B, CH_C,
			CH_A, CH_A, CH_C, CH_C, CH_A, CH_DOT, CH_C};
		lens = '{2, 127, 3, 0, 5, 64, 4, 1, 6, 2, 3, 70};
		lens[8] = $urandom_range(1, 12);
		lens[10] = $urandom_range(1, 12);
		set_idle(0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole mask store so no unwritten entry is ever compared
		write_len(7'd0);
		for (int i = 0; i < MASK_MAX; i++)
			put(OP_LOAD, (i == 0) ? 8'h00 : ((i == MASK_MAX - 1) ? 8'hFF : WILD_BYTE), 6'(i));
		put(OP_TEXT, 8'h00, 6'd0);
		put(OP_TEXT, 8'hFF, 6'd63);
		put(OP_NONE, 8'hFF, 6'd63);
		put(OP_END, 8'hFF, 6'd63);
		quiesce();
		write_len(7'd3);
		put(OP_LOAD, CH_A, 6'd0);
		put(OP_LOAD, WILD_BYTE, 6'd1);
		put(OP_LOAD, CH_C, 6'd2);
		foreach (demo_text[i])
			put(OP_TEXT, demo_text[i], 6'd0);
		// line feed in the mask can never match
		put(OP_LOAD, LF_BYTE, 6'd1);
		put(OP_TEXT, CH_A, 6'd0);
		put(OP_TEXT, LF_BYTE, 6'd0);
		put(OP_TEXT, CH_C, 6'd0);
		put(OP_END, 8'h00, 6'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			quiesce();
			if (ph == PHASES / 2) begin
				// every byte hits, receiver holds off: output side backs up
				set_idle(0);
				write_len(7'd1);
				put(OP_LOAD, WILD_BYTE, 6'd0);
				holdoff_req = 1'b1;
				for (int i = 0; i < 40; i++)
					put(OP_TEXT, CH_A + 8'($urandom_range(2)), 6'($urandom_range(63)));
				quiesce();
			end
			set_idle(ph % 4);
			write_len(7'(lens[ph]));
			nloads = (sb.mask_len <= 16) ? sb.mask_len : 6;
			for (int i = 0; i < nloads; i++)
				put(OP_LOAD, mask_byte(),
					(sb.mask_len <= 16) ? 6'(i) : 6'($urandom_range(63)));
			budget = 0;
			while (budget < 85) begin
				r = $urandom_range(99);
				if (r < 45) begin
					send_fragment();
					budget += sb.mask_len;
				end else if (r < 75) begin
					put(OP_TEXT, text_byte(), 6'($urandom_range(63)));
					budget++;
				end else if (r < 85) begin
					put(OP_LOAD, mask_byte(), 6'($urandom_range(63)));
					budget++;
				end else if (r < 92) begin
					put(OP_TEXT, 8'($urandom_range(255)), 6'($urandom_range(63)));
					budget++;
				end else if (r < 96) begin
					put(OP_END, 8'($urandom_range(255)), 6'($urandom_range(63)));
					budget++;
				end else if (r < 98) begin
					put(OP_NONE, 8'($urandom_range(255)), 6'($urandom_range(63)));
				end else begin
					wait_drained();
				end
			end
		end

		quiesce();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("wildcard_mask_line_search_tb OK");
		else
			$display("wildcard_mask_line_search_tb NOT OK");
		$finish;
	end

endmodule

/* wildcard_mask_line_search.f */
+incdir+design
design/wms_pkg.sv
design/wms_front.sv
design/wms_fifo.sv
design/wms_back.sv
design/wildcard_mask_line_search.sv
dv/wildcard_mask_line_search_tb.sv
